/* hw/rtl/set_assoc_cache_lookup_replace_unit_assert.svh */
// Assertion macros shared by the cache lookup RTL.
`ifndef SET_ASSOC_CACHE_LOOKUP_REPLACE_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LOOKUP_REPLACE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SALRU_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SALRU_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/salru_pkg.sv */
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative cache lookup unit.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int unsigned TAG_W   = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned CNT_W   = 64;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  localparam int unsigned MOD_BITS_PER_STEP = 4;
  localparam logic [2:0]  MOD_LAST_STEP     = 3'd7;

  localparam logic [1:0] CFG_OFFSET = 2'd0;
  localparam logic [1:0] CFG_INDEX  = 2'd1;
  localparam logic [1:0] CFG_WAYS   = 2'd2;
  localparam logic [1:0] CFG_POLICY = 2'd3;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  localparam logic [4:0] RST_OFFSET = 5'd4;
  localparam logic [3:0] RST_INDEX  = 4'd8;
  localparam logic [3:0] RST_WAYS   = 4'd8;
  localparam logic [1:0] RST_POLICY = POL_LRU;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETMOD,
    S_LOOK,
    S_SCAN,
    S_VICMOD,
    S_WRITE
  } state_e;

endpackage

/* hw/rtl/salru_mem.sv */
// ----------------------------------------------------------------------------
// salru_mem
// Set memory: one row per set, one write and one registered read port.
// ----------------------------------------------------------------------------
module salru_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 1280
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/salru_mod.sv */
// ----------------------------------------------------------------------------
// salru_mod
// Iterative remainder unit: 32-bit value modulo a narrow divisor, four
// bits per cycle.
// ----------------------------------------------------------------------------
module salru_mod #(
  parameter int unsigned DIV_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      value_i,
  input  logic [DIV_W-1:0] div_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);
  import salru_pkg::*;

  logic             run_q;
  logic [2:0]       cnt_q;
  logic [31:0]      val_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] rem_d;

  always_comb begin
    logic [DIV_W:0] r2;
    rem_d = rem_q;
    for (int k = 0; k < MOD_BITS_PER_STEP; k++) begin
      r2 = {rem_d, val_q[31-k]};
      if (r2 >= {1'b0, div_q}) begin
        r2 = r2 - {1'b0, div_q};
      end
      rem_d = r2[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == MOD_LAST_STEP) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      div_q <= div_i;
      rem_q <= '0;
    end else if (run_q) begin
      val_q <= val_q << MOD_BITS_PER_STEP;
      rem_q <= rem_d;
    end
  end

  assign done_o = run_q && (cnt_q == MOD_LAST_STEP);
  assign rem_o  = rem_d;

endmodule

/* hw/rtl/set_assoc_cache_lookup_replace_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_replace_unit
// Set-associative cache lookup with random, FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// One item at a time; a new item is taken only in idle. A hit or a fill of
// a free way goes through set read, evaluate and write-back; the result
// is registered in the write-back state once the output is not stalled. A
// FIFO or LRU eviction adds an oldest-stamp scan over the ways in use; a
// random eviction adds a pass through the remainder unit. With MAX_SETS not
// a power of two, the set index is first reduced by a reciprocal multiply.
// After reset a clearing pass empties every row of the set memory before
// the first item.
`include "set_assoc_cache_lookup_replace_unit_assert.svh"

module set_assoc_cache_lookup_replace_unit #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [4:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           raw_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [2:0]            way_o,
  output logic                  replaced_valid_o,
  output logic [salru_pkg::CNT_W-1:0] hit_total_o,
  output logic [salru_pkg::CNT_W-1:0] miss_total_o
);
  import salru_pkg::*;

  localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned CLR_W    = $clog2(MAX_SETS + 1);
  localparam int unsigned DIV_W    = WCNT_W;
  localparam bit          SETS_P2  = ((MAX_SETS & (MAX_SETS - 1)) == 0);
  localparam int unsigned TAG_OFS  = MAX_WAYS;
  localparam int unsigned FILL_OFS = TAG_OFS + MAX_WAYS * TAG_W;
  localparam int unsigned USE_OFS  = FILL_OFS + MAX_WAYS * STAMP_W;
  localparam int unsigned ROW_W    = USE_OFS + MAX_WAYS * STAMP_W;
  localparam int unsigned IDX_W    = 15;
  localparam int unsigned RCP_SH   = IDX_W + SET_W;
  localparam int unsigned RCP_W    = IDX_W + 2;
  localparam int unsigned PRD_W    = IDX_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + 64'(MAX_SETS - 1)) / 64'(MAX_SETS));

  state_e state_q, state_d;

  logic [4:0] off_q;
  logic [3:0] idxb_q;
  logic [3:0] ways_cfg_q;
  logic [1:0] pol_q;

  logic [CLR_W-1:0]   clr_q, clr_d;
  logic [SET_W-1:0]   set_q, set_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic               hit_q, hit_d;
  logic               evict_q, evict_d;
  logic [WAY_W-1:0]   target_q, target_d;
  logic [WCNT_W-1:0]  scan_q, scan_d;
  logic [STAMP_W-1:0] best_q, best_d;
  logic [CNT_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]   miss_cnt_q, miss_cnt_d;
  logic [31:0]        lfsr_q, lfsr_d, lfsr_next;
  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_evict_q;
  logic [2:0]         out_way_q;
  logic [CNT_W-1:0]   out_hit_tot_q, out_miss_tot_q;
  logic               out_load;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   quo_q, quo_d;
  logic               sphase_q, sphase_d;
  logic [PRD_W-1:0]   quo_prod;
  logic [IDX_W-1:0]   set_rem;

  logic [WCNT_W-1:0] ways;
  logic [31:0]       addr, idx_mask, idx_raw;
  logic [5:0]        shift;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W-1:0]  set_p2;

  logic             mem_we, mem_re;
  logic [SET_W-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata, row;

  logic             mod_start, mod_done;
  logic [31:0]      mod_value;
  logic [DIV_W-1:0] mod_div, mod_rem;

  logic [MAX_WAYS-1:0] hit_vec, free_vec;
  logic [WAY_W-1:0]    hit_way, free_way;
  logic [STAMP_W-1:0]  scan_stamp, first_stamp;
  logic [WAY_W+2:0]    way_ext;
  logic                in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= RST_OFFSET;
      idxb_q     <= RST_INDEX;
      ways_cfg_q <= RST_WAYS;
      pol_q      <= RST_POLICY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET: off_q      <= cfg_data_i;
        CFG_INDEX:  idxb_q     <= cfg_data_i[3:0];
        CFG_WAYS:   ways_cfg_q <= cfg_data_i[3:0];
        CFG_POLICY: pol_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways_cfg_q == 4'd0) begin
      ways = WCNT_W'(1);
    end else if (32'(ways_cfg_q) > MAX_WAYS) begin
      ways = WCNT_W'(MAX_WAYS);
    end else begin
      ways = WCNT_W'(ways_cfg_q);
    end
  end

  assign addr      = {raw_word_i[7:0], raw_word_i[15:8], raw_word_i[23:16], raw_word_i[31:24]};
  assign idx_mask  = (32'd1 << idxb_q) - 32'd1;
  assign idx_raw   = (addr >> off_q) & idx_mask;
  assign set_p2    = SET_W'(idx_raw & 32'(MAX_SETS - 1));
  assign shift     = {1'b0, off_q} + {2'b00, idxb_q};
  assign tag_in    = (shift >= 6'd32) ? '0 : (addr >> shift);
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = !out_valid_q || !out_stall_i;
  assign quo_prod  = PRD_W'(idx_q) * PRD_W'(RCP_MUL);
  assign quo_d     = IDX_W'(quo_prod >> RCP_SH);
  assign set_rem   = idx_q - IDX_W'(quo_q * IDX_W'(MAX_SETS));

  always_comb begin
    hit_vec  = '0;
    free_vec = '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (32'(w) < 32'(ways)) begin
        hit_vec[w]  = row[w] && (row[TAG_OFS + w*TAG_W +: TAG_W] == tag_q);
        free_vec[w] = !row[w];
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (pol_q == POL_FIFO) begin
      scan_stamp  = row[FILL_OFS + 32'(scan_q[WAY_W-1:0]) * STAMP_W +: STAMP_W];
      first_stamp = row[FILL_OFS +: STAMP_W];
    end else begin
      scan_stamp  = row[USE_OFS + 32'(scan_q[WAY_W-1:0]) * STAMP_W +: STAMP_W];
      first_stamp = row[USE_OFS +: STAMP_W];
    end
  end

  always_comb begin
    mem_wdata = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == target_q) begin
        mem_wdata[USE_OFS + w*STAMP_W +: STAMP_W] = acc_q;
        if (!hit_q) begin
          mem_wdata[w]                                = 1'b1;
          mem_wdata[TAG_OFS + w*TAG_W +: TAG_W]       = tag_q;
          mem_wdata[FILL_OFS + w*STAMP_W +: STAMP_W]  = acc_q;
        end
      end
    end
    if (state_q == S_CLEAR) begin
      mem_wdata = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    hit_d       = hit_q;
    evict_d     = evict_q;
    target_d    = target_q;
    scan_d      = scan_q;
    best_d      = best_q;
    acc_d       = acc_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    lfsr_d      = lfsr_q;
    idx_d       = idx_q;
    sphase_d    = sphase_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_re      = 1'b0;
    mem_raddr   = set_p2;
    mod_start   = 1'b0;
    mod_value   = lfsr_next;
    mod_div     = DIV_W'(ways);
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[SET_W-1:0];
        clr_d     = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(MAX_SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          tag_d = tag_in;
          if (SETS_P2) begin
            set_d   = set_p2;
            mem_re  = 1'b1;
            state_d = S_LOOK;
          end else begin
            idx_d   = IDX_W'(idx_raw);
            state_d = S_SETMOD;
          end
        end
      end
      S_SETMOD: begin
        if (!sphase_q) begin
          sphase_d = 1'b1;
        end else begin
          sphase_d  = 1'b0;
          set_d     = SET_W'(set_rem);
          mem_re    = 1'b1;
          mem_raddr = SET_W'(set_rem);
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        acc_d   = acc_q + CNT_W'(1);
        evict_d = 1'b0;
        state_d = S_WRITE;
        if (|hit_vec) begin
          hit_d     = 1'b1;
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
          target_d  = hit_way;
        end else begin
          hit_d      = 1'b0;
          miss_cnt_d = miss_cnt_q + CNT_W'(1);
          if (|free_vec) begin
            target_d = free_way;
          end else begin
            evict_d = 1'b1;
            unique case (pol_q)
              POL_RANDOM: begin
                lfsr_d    = lfsr_next;
                mod_start = 1'b1;
                mod_value = lfsr_next;
                mod_div   = DIV_W'(ways);
                state_d   = S_VICMOD;
              end
              POL_FIFO, POL_LRU: begin
                target_d = '0;
                best_d   = first_stamp;
                scan_d   = WCNT_W'(1);
                state_d  = S_SCAN;
              end
              default: target_d = '0;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (scan_q >= ways) begin
          state_d = S_WRITE;
        end else begin
          if (scan_stamp < best_q) begin
            best_d   = scan_stamp;
            target_d = scan_q[WAY_W-1:0];
          end
          scan_d = scan_q + WCNT_W'(1);
        end
      end
      S_VICMOD: begin
        mod_div = DIV_W'(ways);
        if (mod_done) begin
          target_d = WAY_W'(mod_rem);
          state_d  = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      acc_q       <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      sphase_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      acc_q       <= acc_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      sphase_q    <= sphase_d;
    end
  end

  assign way_ext = {3'b000, target_q};

  always_ff @(posedge clk_i) begin
    set_q    <= set_d;
    tag_q    <= tag_d;
    hit_q    <= hit_d;
    evict_q  <= evict_d;
    target_q <= target_d;
    best_q   <= best_d;
    idx_q    <= idx_d;
    quo_q    <= quo_d;
    if (state_q == S_WRITE && out_load) begin
      out_hit_q      <= hit_q;
      out_evict_q    <= evict_q;
      out_way_q      <= way_ext[2:0];
      out_hit_tot_q  <= hit_cnt_q;
      out_miss_tot_q <= miss_cnt_q;
    end
  end

  salru_mem #(
    .DEPTH  (MAX_SETS),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (row)
  );

  salru_mod #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .div_i   (mod_div),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign way_o            = out_way_q;
  assign replaced_valid_o = out_evict_q;
  assign hit_total_o      = out_hit_tot_q;
  assign miss_total_o     = out_miss_tot_q;

  `SALRU_ASSERT_NOW(a_cnt_sum, clk_i, rst_ni, (state_q == S_IDLE) |-> (acc_q == hit_cnt_q + miss_cnt_q), "access count differs from hit plus miss count")
  `SALRU_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_accept, state_q != S_IDLE, "idle right after accepting an item")
  `SALRU_ASSERT_NOW(a_hit_evict, clk_i, rst_ni, (out_valid_o && hit_o) |-> !replaced_valid_o, "hit reported with eviction")
  `SALRU_ASSERT_NOW(a_target, clk_i, rst_ni, (state_q == S_WRITE) |-> (32'(target_q) < 32'(ways)), "target way beyond ways in use")

endmodule
